FILE: rtl/core/utf8_query_tokenizer_macros.svh
// assertion macros for the utf8 query tokenizer
`ifndef UTF8_QUERY_TOKENIZER_MACROS_SVH
`define UTF8_QUERY_TOKENIZER_MACROS_SVH

// same-cycle implication, checked outside reset
`define UQT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UQT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/uqt_pkg.sv
// constants and helpers shared by the utf8 query tokenizer
`timescale 1ns / 1ps

package uqt_pkg;

    localparam int MAX_TOKENS_DEF  = 32;
    localparam int WORD_BYTES_DEF  = 64;
    localparam int QUERY_BYTES_DEF = 256;

    // holds token counts up to 511
    localparam int TOKEN_WIDE = 9;

    localparam logic [15:0] CJK_MAIN_LO  = 16'h4E00;
    localparam logic [15:0] CJK_MAIN_HI  = 16'h9FFF;
    localparam logic [15:0] CJK_EXT_LO   = 16'h3400;
    localparam logic [15:0] CJK_EXT_HI   = 16'h4DBF;
    localparam logic [15:0] CJK_COMPAT_LO = 16'hF900;
    localparam logic [15:0] CJK_COMPAT_HI = 16'hFAFF;
    localparam logic [15:0] CJK_PUNCT_LO = 16'h3000;
    localparam logic [15:0] CJK_PUNCT_HI = 16'h303F;
    localparam logic [15:0] FULLWIDTH_LO = 16'hFF00;
    localparam logic [15:0] FULLWIDTH_HI = 16'hFFEF;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic [1:0] TAIL2 = 2'd1;
    localparam logic [1:0] TAIL3 = 2'd2;
    localparam logic [1:0] TAIL4 = 2'd3;

    function automatic logic is_ideograph(logic [7:0] lead, logic [7:0] mid, logic [7:0] last);
        logic [15:0] cp;
        cp = {lead[3:0], mid[5:0], last[5:0]};
        if (cp >= CJK_PUNCT_LO && cp <= CJK_PUNCT_HI)
            return 1'b0;
        if (cp >= FULLWIDTH_LO && cp <= FULLWIDTH_HI)
            return 1'b0;
        return (cp >= CJK_MAIN_LO && cp <= CJK_MAIN_HI) ||
               (cp >= CJK_EXT_LO && cp <= CJK_EXT_HI) ||
               (cp >= CJK_COMPAT_LO && cp <= CJK_COMPAT_HI);
    endfunction

    function automatic logic is_alnum(logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_upper(logic [7:0] b);
        return b >= 8'h41 && b <= 8'h5A;
    endfunction

endpackage

FILE: rtl/core/utf8_query_tokenizer.sv
// Streaming UTF-8 query tokenizer. One text byte is taken per cycle on the
// in_valid/in_ready channel; each byte gives zero or one result in the next cycle
// on out_valid/out_ready. The result register is the only stage, so a new byte
// is taken every cycle while the result side keeps up; in_ready drops only when
// a result waits and out_ready is low. Letters and digits come out one byte at
// a time (lowercased) with their token index, a word ending is marked by
// token_end, a CJK ideograph comes out whole on cjk_sequence, and the result
// for the byte flagged final_byte carries query_end and token_total, after which
// the tokenizer is ready for the next query. There is no reset-time sweep.
`timescale 1ns / 1ps

`include "utf8_query_tokenizer_macros.svh"

module utf8_query_tokenizer #(
    parameter int MAX_TOKENS  = uqt_pkg::MAX_TOKENS_DEF,
    parameter int WORD_BYTES  = uqt_pkg::WORD_BYTES_DEF,
    parameter int QUERY_BYTES = uqt_pkg::QUERY_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_valid,
    output logic [7:0]  word_byte,
    output logic        cjk_valid,
    output logic [23:0] cjk_sequence,
    output logic        token_end,
    output logic [4:0]  token_index,
    output logic        query_end,
    output logic [5:0]  token_total
);

    localparam int TW  = $clog2(MAX_TOKENS + 1);
    localparam int WLW = $clog2(WORD_BYTES);
    localparam int BW  = $clog2(QUERY_BYTES);

    localparam logic [TW-1:0]  TOKEN_LIMIT = TW'(MAX_TOKENS);
    localparam logic [WLW-1:0] WORD_LIMIT  = WLW'(WORD_BYTES - 1);
    localparam logic [BW-1:0]  BYTE_LIMIT  = BW'(QUERY_BYTES - 1);

    // tokenizer state
    logic           in_word_reg, in_word_next;
    logic [WLW-1:0] word_length_reg, word_length_next;
    logic [TW-1:0]  tokens_done_reg, tokens_done_next;
    logic [15:0]    pending_reg, pending_next;
    logic [1:0]     bytes_to_come_reg, bytes_to_come_next;
    logic           char3_reg, char3_next;
    logic [BW-1:0]  bytes_seen_reg, bytes_seen_next;
    logic           halted_reg, halted_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        byte_valid_reg, byte_valid_next;
    logic [7:0]  word_byte_reg, word_byte_next;
    logic        cjk_valid_reg, cjk_valid_next;
    logic [23:0] cjk_sequence_reg, cjk_sequence_next;
    logic        token_end_reg, token_end_next;
    logic [4:0]  token_index_reg, token_index_next;
    logic        query_end_reg, query_end_next;
    logic [5:0]  token_total_reg, token_total_next;

    logic accept;
    logic ignore_byte;
    logic close_req;
    logic any_result;
    logic [TW-1:0] result_index;
    logic [uqt_pkg::TOKEN_WIDE-1:0] index_wide;
    logic [uqt_pkg::TOKEN_WIDE-1:0] total_wide;
    logic [1:0] tail_left;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        in_word_next       = in_word_reg;
        word_length_next   = word_length_reg;
        tokens_done_next   = tokens_done_reg;
        pending_next       = pending_reg;
        bytes_to_come_next = bytes_to_come_reg;
        char3_next         = char3_reg;
        bytes_seen_next    = bytes_seen_reg;
        halted_next        = halted_reg;

        byte_valid_next    = 1'b0;
        word_byte_next     = 8'h00;
        cjk_valid_next     = 1'b0;
        cjk_sequence_next  = 24'h000000;
        token_end_next     = 1'b0;
        query_end_next     = 1'b0;
        token_total_next   = 6'd0;
        result_index       = '0;
        any_result         = 1'b0;
        close_req          = 1'b0;
        tail_left          = bytes_to_come_reg - 2'd1;

        ignore_byte = halted_reg || (bytes_seen_reg >= BYTE_LIMIT) || (text_byte == 8'h00);

        priority if (ignore_byte)
        begin
            close_req          = 1'b1;
            bytes_to_come_next = 2'd0;
            char3_next         = 1'b0;
            pending_next       = 16'h0000;
            if (text_byte == 8'h00)
                halted_next = 1'b1;
        end
        else if (tokens_done_reg >= TOKEN_LIMIT)
        begin
            bytes_seen_next = bytes_seen_reg + BW'(1);
        end
        else
        begin
            bytes_seen_next = bytes_seen_reg + BW'(1);
            if (bytes_to_come_reg != 2'd0)
            begin
                bytes_to_come_next = tail_left;
                if (tail_left == 2'd0)
                begin
                    if (char3_reg &&
                        uqt_pkg::is_ideograph(pending_reg[15:8], pending_reg[7:0], text_byte))
                    begin
                        cjk_valid_next    = 1'b1;
                        cjk_sequence_next = {pending_reg, text_byte};
                        token_end_next    = 1'b1;
                        result_index      = tokens_done_reg;
                        tokens_done_next  = tokens_done_reg + TW'(1);
                        any_result        = 1'b1;
                    end
                    char3_next   = 1'b0;
                    pending_next = 16'h0000;
                end
                else
                begin
                    pending_next = {pending_reg[7:0], text_byte};
                end
            end
            else if (!text_byte[7])
            begin
                if (uqt_pkg::is_alnum(text_byte))
                begin
                    in_word_next = 1'b1;
                    // word_length is zero whenever no word is open
                    if (word_length_reg < WORD_LIMIT)
                    begin
                        word_length_next = word_length_reg + WLW'(1);
                        byte_valid_next  = 1'b1;
                        word_byte_next   = uqt_pkg::is_upper(text_byte) ?
                                           text_byte + 8'd32 : text_byte;
                        result_index     = tokens_done_reg;
                        any_result       = 1'b1;
                    end
                end
                else
                begin
                    close_req = 1'b1;
                end
            end
            else
            begin
                close_req = 1'b1;
                if ((text_byte & uqt_pkg::LEAD2_MASK) == uqt_pkg::LEAD2_CODE)
                begin
                    bytes_to_come_next = uqt_pkg::TAIL2;
                    pending_next       = {8'h00, text_byte};
                end
                else if ((text_byte & uqt_pkg::LEAD3_MASK) == uqt_pkg::LEAD3_CODE)
                begin
                    bytes_to_come_next = uqt_pkg::TAIL3;
                    char3_next         = 1'b1;
                    pending_next       = {8'h00, text_byte};
                end
                else if ((text_byte & uqt_pkg::LEAD4_MASK) == uqt_pkg::LEAD4_CODE)
                begin
                    bytes_to_come_next = uqt_pkg::TAIL4;
                    pending_next       = {8'h00, text_byte};
                end
            end
        end

        // closing a word never coincides with a finished ideograph
        if (close_req && in_word_reg)
        begin
            token_end_next   = 1'b1;
            result_index     = tokens_done_reg;
            tokens_done_next = tokens_done_reg + TW'(1);
            in_word_next     = 1'b0;
            word_length_next = '0;
            any_result       = 1'b1;
        end

        total_wide = '0;
        if (final_byte)
        begin
            if (in_word_next)
            begin
                token_end_next   = 1'b1;
                result_index     = tokens_done_next;
                tokens_done_next = tokens_done_next + TW'(1);
            end
            any_result         = 1'b1;
            query_end_next     = 1'b1;
            total_wide         = uqt_pkg::TOKEN_WIDE'(tokens_done_next);
            token_total_next   = total_wide[5:0];
            in_word_next       = 1'b0;
            word_length_next   = '0;
            tokens_done_next   = '0;
            pending_next       = 16'h0000;
            bytes_to_come_next = 2'd0;
            char3_next         = 1'b0;
            bytes_seen_next    = '0;
            halted_next        = 1'b0;
        end

        index_wide       = uqt_pkg::TOKEN_WIDE'(result_index);
        token_index_next = index_wide[4:0];

        if (accept)
            out_valid_next = any_result;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg       <= 1'b0;
            word_length_reg   <= '0;
            tokens_done_reg   <= '0;
            pending_reg       <= 16'h0000;
            bytes_to_come_reg <= 2'd0;
            char3_reg         <= 1'b0;
            bytes_seen_reg    <= '0;
            halted_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                in_word_reg       <= in_word_next;
                word_length_reg   <= word_length_next;
                tokens_done_reg   <= tokens_done_next;
                pending_reg       <= pending_next;
                bytes_to_come_reg <= bytes_to_come_next;
                char3_reg         <= char3_next;
                bytes_seen_reg    <= bytes_seen_next;
                halted_reg        <= halted_next;
            end
        end
    end

    // payload loads only with an accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_valid_reg   <= byte_valid_next;
            word_byte_reg    <= word_byte_next;
            cjk_valid_reg    <= cjk_valid_next;
            cjk_sequence_reg <= cjk_sequence_next;
            token_end_reg    <= token_end_next;
            token_index_reg  <= token_index_next;
            query_end_reg    <= query_end_next;
            token_total_reg  <= token_total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_valid   = byte_valid_reg;
    assign word_byte    = word_byte_reg;
    assign cjk_valid    = cjk_valid_reg;
    assign cjk_sequence = cjk_sequence_reg;
    assign token_end    = token_end_reg;
    assign token_index  = token_index_reg;
    assign query_end    = query_end_reg;
    assign token_total  = token_total_reg;

    `UQT_ASSERT_NOW(a_word_len_open, clk, rst_n, 1'b1, in_word_reg == (word_length_reg != '0), "word length disagrees with open word")
    `UQT_ASSERT_NOW(a_halt_clean, clk, rst_n, halted_reg, !in_word_reg && bytes_to_come_reg == 2'd0, "state left open after zero byte")
    `UQT_ASSERT_NOW(a_token_bound, clk, rst_n, 1'b1, tokens_done_reg <= TOKEN_LIMIT, "token count past its limit")
    `UQT_ASSERT_NEXT(a_final_result, clk, rst_n, accept && final_byte, out_valid_reg && query_end_reg && tokens_done_reg == '0 && bytes_seen_reg == '0, "final byte did not end the query")

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the utf8 query tokenizer: directed and random queries
`timescale 1ns / 1ps

typedef struct packed {
    logic        byte_valid;
    logic [7:0]  word_byte;
    logic        cjk_valid;
    logic [23:0] cjk_sequence;
    logic        token_end;
    logic [4:0]  token_index;
    logic        query_end;
    logic [5:0]  token_total;
} token_result_t;

class token_scoreboard;
    bit            in_word;
    int unsigned   word_len;
    int unsigned   token_count;
    logic [15:0]   lead_pair;
    int unsigned   tail_left;
    int unsigned   char_len;
    int unsigned   taken;
    bit            stopped;
    token_result_t step_out;
    bit            step_any;
    token_result_t awaited[$];
    int unsigned   mismatches;

    function new();
        mismatches = 0;
        clear_state();
    endfunction

    function void clear_state();
        in_word     = 1'b0;
        word_len    = 0;
        token_count = 0;
        lead_pair   = '0;
        tail_left   = 0;
        char_len    = 0;
        taken       = 0;
        stopped     = 1'b0;
    endfunction

    function void close_open_word();
        if (in_word)
        begin
            step_out.token_end   = 1'b1;
            step_out.token_index = token_count[4:0];
            token_count++;
            in_word  = 1'b0;
            word_len = 0;
            step_any = 1'b1;
        end
    endfunction

    // code point from a three-byte sequence, punctuation and fullwidth excluded
    function bit ideograph_code(logic [7:0] lead, logic [7:0] mid, logic [7:0] last);
        logic [15:0] cp;
        bit          punct;
        bit          fullwidth;
        bit          han;
        cp        = {lead[3:0], mid[5:0], last[5:0]};
        punct     = cp >= uqt_pkg::CJK_PUNCT_LO && cp <= uqt_pkg::CJK_PUNCT_HI;
        fullwidth = cp >= uqt_pkg::FULLWIDTH_LO && cp <= uqt_pkg::FULLWIDTH_HI;
        han       = (cp >= uqt_pkg::CJK_MAIN_LO && cp <= uqt_pkg::CJK_MAIN_HI)
                 || (cp >= uqt_pkg::CJK_EXT_LO && cp <= uqt_pkg::CJK_EXT_HI)
                 || (cp >= uqt_pkg::CJK_COMPAT_LO && cp <= uqt_pkg::CJK_COMPAT_HI);
        return !punct && !fullwidth && han;
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
        bit         word_char;
        logic [7:0] lower;
        step_out = '0;
        step_any = 1'b0;
        word_char = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A)
                 || (b >= 8'h61 && b <= 8'h7A);
        lower = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
        if (stopped || taken >= uqt_pkg::QUERY_BYTES_DEF - 1 || b == 8'h00)
        begin
            close_open_word();
            tail_left = 0;
            char_len  = 0;
            lead_pair = '0;
            if (b == 8'h00)
                stopped = 1'b1;
        end
        else if (token_count >= uqt_pkg::MAX_TOKENS_DEF)
        begin
            taken++;
        end
        else
        begin
            taken++;
            if (tail_left > 0)
            begin
                tail_left--;
                if (tail_left == 0)
                begin
                    if (char_len == 3 && ideograph_code(lead_pair[15:8], lead_pair[7:0], b))
                    begin
                        step_out.cjk_valid    = 1'b1;
                        step_out.cjk_sequence = {lead_pair, b};
                        step_out.token_end    = 1'b1;
                        step_out.token_index  = token_count[4:0];
                        token_count++;
                        step_any = 1'b1;
                    end
                    char_len  = 0;
                    lead_pair = '0;
                end
                else
                begin
                    lead_pair = {lead_pair[7:0], b};
                end
            end
            else if (b < 8'h80)
            begin
                if (word_char)
                begin
                    if (!in_word)
                    begin
                        in_word  = 1'b1;
                        word_len = 0;
                    end
                    // overlong words are absorbed silently
                    if (word_len < uqt_pkg::WORD_BYTES_DEF - 1)
                    begin
                        word_len++;
                        step_out.byte_valid  = 1'b1;
                        step_out.word_byte   = lower;
                        step_out.token_index = token_count[4:0];
                        step_any = 1'b1;
                    end
                end
                else
                begin
                    close_open_word();
                end
            end
            else
            begin
                close_open_word();
                if (b[7:5] == 3'b110)
                begin
                    tail_left = 1;
                    char_len  = 2;
                    lead_pair = {8'h00, b};
                end
                else if (b[7:4] == 4'b1110)
                begin
                    tail_left = 2;
                    char_len  = 3;
                    lead_pair = {8'h00, b};
                end
                else if (b[7:3] == 5'b11110)
                begin
                    tail_left = 3;
                    char_len  = 4;
                    lead_pair = {8'h00, b};
                end
            end
        end

        if (fin)
        begin
            if (in_word)
            begin
                step_out.token_end   = 1'b1;
                step_out.token_index = token_count[4:0];
                token_count++;
                in_word = 1'b0;
            end
            step_any             = 1'b1;
            step_out.query_end   = 1'b1;
            step_out.token_total = token_count[5:0];
            clear_state();
        end

        if (step_any)
            awaited.push_back(step_out);
    endfunction

    function string show(token_result_t r);
        return $sformatf("bv=%0b wb=%02h cv=%0b cs=%06h te=%0b ti=%0d qe=%0b tt=%0d",
                         r.byte_valid, r.word_byte, r.cjk_valid, r.cjk_sequence,
                         r.token_end, r.token_index, r.query_end, r.token_total);
    endfunction

    function void check_result(token_result_t got);
        token_result_t want;
        if (awaited.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result with nothing expected: %s", $time, show(got));
            return;
        end
        want = awaited.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result mismatch\n  expected %s\n  actual   %s",
                         $time, show(want), show(got));
        end
    endfunction
endclass

module tb_top;
    typedef enum {MIXED, LONG_WORD, MANY_TOKENS, LONG_QUERY, NOISE} query_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  text_byte = 8'h00;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        byte_valid;
    logic [7:0]  word_byte;
    logic        cjk_valid;
    logic [23:0] cjk_sequence;
    logic        token_end;
    logic [4:0]  token_index;
    logic        query_end;
    logic [5:0]  token_total;

    token_scoreboard sb = new();

    int unsigned in_idle_pct = 18;
    int unsigned out_idle_pct = 18;
    int unsigned items_sent = 0;
    int unsigned stall_cycles = 0;
    logic [7:0]  qbytes[$];

    always #5 clk = ~clk;

    utf8_query_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_valid   (byte_valid),
        .word_byte    (word_byte),
        .cjk_valid    (cjk_valid),
        .cjk_sequence (cjk_sequence),
        .token_end    (token_end),
        .token_index  (token_index),
        .query_end    (query_end),
        .token_total  (token_total)
    );

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= out_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result({byte_valid, word_byte, cjk_valid, cjk_sequence,
                             token_end, token_index, query_end, token_total});

    // ends the run if neither side completes a transaction for too long
    initial
    begin
        while (stall_cycles < 2000)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b, fin);
        items_sent++;
    endtask

    task automatic send_query();
        for (int i = 0; i < qbytes.size(); i++)
            send_byte(qbytes[i], i == qbytes.size() - 1);
        qbytes.delete();
    endtask

    function automatic void put_word(int unsigned n);
        int unsigned k;
        repeat (n)
        begin
            k = $urandom_range(61);
            if (k < 10)
                qbytes.push_back(8'h30 + 8'(k));
            else if (k < 36)
                qbytes.push_back(8'h41 + 8'(k - 10));
            else
                qbytes.push_back(8'h61 + 8'(k - 36));
        end
    endfunction

    function automatic void put_sep();
        case ($urandom_range(3))
            0: qbytes.push_back(8'($urandom_range(8'h2F, 8'h01)));
            1: qbytes.push_back(8'($urandom_range(8'h40, 8'h3A)));
            2: qbytes.push_back(8'($urandom_range(8'h60, 8'h5B)));
            default: qbytes.push_back(8'($urandom_range(8'h7F, 8'h7B)));
        endcase
    endfunction

    function automatic void put_char3(logic [15:0] cp);
        qbytes.push_back({4'hE, cp[15:12]});
        qbytes.push_back({2'b10, cp[11:6]});
        qbytes.push_back({2'b10, cp[5:0]});
    endfunction

    function automatic void put_piece();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 35)
            put_word($urandom_range(8, 1));
        else if (p < 55)
            put_sep();
        else if (p < 75)
        begin
            case ($urandom_range(2))
                0: put_char3(16'($urandom_range(uqt_pkg::CJK_MAIN_HI, uqt_pkg::CJK_MAIN_LO)));
                1: put_char3(16'($urandom_range(uqt_pkg::CJK_EXT_HI, uqt_pkg::CJK_EXT_LO)));
                default:
                    put_char3(16'($urandom_range(uqt_pkg::CJK_COMPAT_HI,
                                                 uqt_pkg::CJK_COMPAT_LO)));
            endcase
        end
        else if (p < 82)
        begin
            if ($urandom_range(1))
                put_char3(16'($urandom_range(uqt_pkg::CJK_PUNCT_HI, uqt_pkg::CJK_PUNCT_LO)));
            else
                put_char3(16'($urandom_range(uqt_pkg::FULLWIDTH_HI, uqt_pkg::FULLWIDTH_LO)));
        end
        else if (p < 87)
        begin
            // three-byte lead followed by arbitrary tail bytes
            qbytes.push_back(8'hE0 | 8'($urandom_range(15)));
            qbytes.push_back(8'($urandom_range(255, 1)));
            qbytes.push_back(8'($urandom_range(255, 1)));
        end
        else if (p < 91)
        begin
            qbytes.push_back(8'hC0 | 8'($urandom_range(31)));
            qbytes.push_back(8'h80 | 8'($urandom_range(63)));
        end
        else if (p < 95)
        begin
            qbytes.push_back(8'hF0 | 8'($urandom_range(7)));
            repeat (3)
                qbytes.push_back(8'h80 | 8'($urandom_range(63)));
        end
        else if ($urandom_range(1))
            qbytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
        else
            qbytes.push_back(8'($urandom_range(8'hFF, 8'hF8)));
    endfunction

    initial
    begin
        int unsigned  q;
        int unsigned  r;
        query_style_t style;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // mixed case word, separator, ideograph, cjk space, two-byte char,
        // invalid continuation lead, word closed by the final byte
        qbytes = '{8'h41, 8'h7A, 8'h30, 8'h39, 8'h2F, 8'hE4, 8'hB8, 8'h80,
                   8'hE3, 8'h80, 8'h80, 8'h78, 8'hC3, 8'hA9, 8'h80, 8'h5A};
        send_query();
        // top of the main ideograph range, fullwidth form, four-byte char,
        // invalid high lead, zero byte followed by ignored text
        qbytes = '{8'hE9, 8'hBF, 8'hBF, 8'hEF, 8'hBC, 8'h81, 8'hF0, 8'h9F,
                   8'h98, 8'h80, 8'hFF, 8'h71, 8'h00, 8'h72};
        send_query();

        q = 0;
        while (items_sent < 1230)
        begin
            if (q >= 12 && q < 20)
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            else
            begin
                in_idle_pct  = 18;
                out_idle_pct = 18;
            end

            r = $urandom_range(99);
            if (q == 0)
                style = LONG_QUERY;
            else if (q == 1)
                style = MANY_TOKENS;
            else if (q == 2)
                style = LONG_WORD;
            else if (r < 70)
                style = MIXED;
            else if (r < 78)
                style = LONG_WORD;
            else if (r < 84)
                style = MANY_TOKENS;
            else if (r < 88)
                style = LONG_QUERY;
            else
                style = NOISE;

            case (style)
                MIXED:
                    repeat ($urandom_range(10, 1)) put_piece();
                LONG_WORD:
                begin
                    put_word($urandom_range(72, 60));
                    put_piece();
                end
                MANY_TOKENS:
                    repeat ($urandom_range(42, 34))
                    begin
                        if ($urandom_range(1))
                            put_char3(16'($urandom_range(uqt_pkg::CJK_MAIN_HI,
                                                         uqt_pkg::CJK_MAIN_LO)));
                        else
                        begin
                            put_word($urandom_range(3, 1));
                            put_sep();
                        end
                    end
                LONG_QUERY:
                    while (qbytes.size() < 270)
                        put_piece();
                default:
                    repeat ($urandom_range(20, 1))
                        qbytes.push_back(8'($urandom_range(255)));
            endcase

            // broken queries: character cut by the final byte, early zero byte
            if ($urandom_range(9) == 0 && qbytes.size() > 1)
                void'(qbytes.pop_back());
            if ($urandom_range(9) == 0)
                qbytes.insert($urandom_range(qbytes.size() - 1), 8'h00);

            send_query();
            q++;
        end

        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/uqt_pkg.sv
rtl/core/utf8_query_tokenizer.sv
bench/tb_top.sv
